FILE: rtl/i2cmbw_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbw_pkg
// Shared types and constants for the I2C master single-byte writer.
// ----------------------------------------------------------------------------
package i2cmbw_pkg;

    localparam int unsigned HALF_W        = 16;
    localparam logic [HALF_W-1:0] HALF_RESET = 16'd450;

    typedef struct packed {
        logic       action;
        logic [6:0] target_address;
        logic [7:0] data_byte;
        logic       sda_level;
    } t_in_item;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } t_out_item;

endpackage

FILE: rtl/i2cmbw_seq.sv
// ----------------------------------------------------------------------------
// i2cmbw_seq
// Bus sequencer: phase, bit counter, shift byte, half-period timer and line
// drives. Advances by one item whenever i_step is high.
// ----------------------------------------------------------------------------
module i2cmbw_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  i2cmbw_pkg::t_in_item        i_item,
    input  logic [i2cmbw_pkg::HALF_W-1:0] i_half,
    output i2cmbw_pkg::t_out_item       o_res
);
    import i2cmbw_pkg::*;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_START_A = 4'd1;
    localparam logic [3:0] PH_START_B = 4'd2;
    localparam logic [3:0] PH_ADDR_LO = 4'd3;
    localparam logic [3:0] PH_ADDR_HI = 4'd4;
    localparam logic [3:0] PH_AACK_LO = 4'd5;
    localparam logic [3:0] PH_AACK_HI = 4'd6;
    localparam logic [3:0] PH_DATA_LO = 4'd7;
    localparam logic [3:0] PH_DATA_HI = 4'd8;
    localparam logic [3:0] PH_DACK_LO = 4'd9;
    localparam logic [3:0] PH_DACK_HI = 4'd10;
    localparam logic [3:0] PH_STOP_A  = 4'd11;
    localparam logic [3:0] PH_STOP_B  = 4'd12;
    localparam logic [3:0] PH_STOP_C  = 4'd13;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ADDR_NAK = 2'd1;
    localparam logic [1:0] ST_DATA_NAK = 2'd2;

    logic [3:0]        r_phase,  n_phase;
    logic [3:0]        r_bit,    n_bit;
    logic [7:0]        r_shift,  n_shift;
    logic [7:0]        r_pend,   n_pend;
    logic [HALF_W-1:0] r_dly,    n_dly;
    logic [1:0]        r_status, n_status;
    logic              r_scl,    n_scl;
    logic              r_sda,    n_sda;
    logic              w_done;
    logic [HALF_W-1:0] w_limit;
    logic [HALF_W-1:0] w_dly_inc;
    logic [7:0]        w_shl;
    logic [3:0]        w_bit_inc;

    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_pend    = r_pend;
        n_dly     = r_dly;
        n_status  = r_status;
        n_scl     = r_scl;
        n_sda     = r_sda;
        w_done    = 1'b0;
        w_limit   = (i_half == '0) ? HALF_W'(1) : i_half;
        w_dly_inc = r_dly + HALF_W'(1);
        w_shl     = {r_shift[6:0], 1'b0};
        w_bit_inc = r_bit + 4'd1;

        if (i_item.action) begin
            // start a transaction only from idle; drop the request otherwise
            if (r_phase == PH_IDLE) begin
                n_shift = {i_item.target_address, 1'b0};
                n_pend  = i_item.data_byte;
                n_bit   = 4'd0;
                n_scl   = 1'b0;
                n_sda   = 1'b0;
                n_phase = PH_START_A;
                n_dly   = '0;
            end
        end else if (r_phase != PH_IDLE) begin
            n_dly = w_dly_inc;
            if (w_dly_inc >= w_limit) begin
                n_dly = '0;
                case (r_phase)
                    PH_START_A: begin
                        n_sda   = 1'b1;
                        n_phase = PH_START_B;
                    end
                    PH_START_B: begin
                        n_scl   = 1'b1;
                        n_bit   = 4'd0;
                        n_sda   = ~r_shift[7];
                        n_phase = PH_ADDR_LO;
                    end
                    PH_ADDR_LO, PH_AACK_LO, PH_DATA_LO, PH_DACK_LO, PH_STOP_A: begin
                        n_scl   = 1'b0;
                        n_phase = r_phase + 4'd1;
                    end
                    PH_ADDR_HI, PH_DATA_HI: begin
                        // end of a bit: next bit, or hand the line to the ack
                        n_scl   = 1'b1;
                        n_shift = w_shl;
                        n_bit   = w_bit_inc;
                        if (w_bit_inc < 4'd8) begin
                            n_sda   = ~w_shl[7];
                            n_phase = r_phase - 4'd1;
                        end else begin
                            n_sda   = 1'b0;
                            n_phase = r_phase + 4'd1;
                        end
                    end
                    PH_AACK_HI: begin
                        n_scl = 1'b1;
                        if (i_item.sda_level) begin
                            n_status = ST_ADDR_NAK;
                            n_sda    = 1'b1;
                            n_phase  = PH_STOP_A;
                        end else begin
                            n_shift = r_pend;
                            n_bit   = 4'd0;
                            n_sda   = ~r_pend[7];
                            n_phase = PH_DATA_LO;
                        end
                    end
                    PH_DACK_HI: begin
                        n_scl    = 1'b1;
                        n_status = i_item.sda_level ? ST_DATA_NAK : ST_OK;
                        n_sda    = 1'b1;
                        n_phase  = PH_STOP_A;
                    end
                    PH_STOP_B: begin
                        n_sda   = 1'b0;
                        n_phase = PH_STOP_C;
                    end
                    PH_STOP_C: begin
                        n_phase = PH_IDLE;
                        w_done  = 1'b1;
                    end
                    default: begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_res.scl_pull_low = n_scl;
        o_res.sda_pull_low = n_sda;
        o_res.busy_res     = (n_phase != PH_IDLE);
        o_res.done_res     = w_done;
        o_res.status       = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bit    <= '0;
            r_shift  <= '0;
            r_pend   <= '0;
            r_dly    <= '0;
            r_status <= ST_OK;
            r_scl    <= 1'b0;
            r_sda    <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_pend   <= n_pend;
            r_dly    <= n_dly;
            r_status <= n_status;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.done_res |=> r_phase == PH_IDLE)
        else $error("finished transaction did not return to idle");

    a_busy_req_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.action && r_phase != PH_IDLE
        |=> $stable(r_phase) && $stable(r_dly) && $stable(r_shift))
        else $error("request while busy disturbed the transaction");

    a_hold_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_dly) && $stable(r_status))
        else $error("sequencer advanced without an item");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $changed(r_status) |-> r_phase == PH_STOP_A)
        else $error("status changed outside the ack phases");

endmodule

FILE: rtl/i2c_master_byte_writer_top.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_writer_top
// I2C master that runs one single-byte write transaction per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries items that are
//   either one tick of bus time or a write request (7-bit target, data byte).
//   Each accepted item yields exactly one result item on the output channel
//   (o_out_valid / i_out_ready / o_out_data): the clock and data pull-low
//   drives, busy, done and the last completion status.
//   Timing: an item lands in the input register at its accepting edge, the
//   sequencer works on it combinationally once the output register is free,
//   and its result then enters the output register, which drives o_out_valid
//   and o_out_data.
//   Throughput: one item per clock while i_out_ready is high; the sequencer
//   does one bus tick per item and the two registers overlap consecutive items.
//   Stall: when the receiver holds i_out_ready low, the result is held, the
//   input register holds its item, and o_in_ready drops once both are full.
//   Configuration: i_cfg_we writes the half-period register (ticks per half
//   bit phase, zero acts as one); write it only while idle.
//   Reset (synchronous, active low): pipeline emptied, bus lines released,
//   status cleared, half period back to 450.
// ----------------------------------------------------------------------------
module i2c_master_byte_writer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  i2cmbw_pkg::t_in_item           i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output i2cmbw_pkg::t_out_item          o_out_data,
    input  logic                           i_cfg_we,
    input  logic [i2cmbw_pkg::HALF_W-1:0]  i_cfg_wdata
);
    import i2cmbw_pkg::*;

    logic              r_in_vld;
    t_in_item          r_in;
    logic              r_out_vld;
    t_out_item         r_out;
    logic [HALF_W-1:0] r_half;
    logic              w_out_free;
    logic              w_step;
    t_out_item         w_res;

    // output register can take a result when empty or being drained
    assign w_out_free = ~r_out_vld | i_out_ready;
    // advance the sequencer when the input register holds an item and the
    // result has somewhere to go
    assign w_step     = r_in_vld & w_out_free;
    assign o_in_ready = ~r_in_vld | w_out_free;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RESET;
        end else if (i_cfg_we) begin
            r_half <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    i2cmbw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_in),
        .i_half  (r_half),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

endmodule
